// ----- src/positional_list_engine_unit_assert.svh -----
// ----------------------------------------------------------------------------
// positional list engine assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PLEU_ASSERT_NOW(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define PLEU_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pleu_pkg.sv -----
// ----------------------------------------------------------------------------
// pleu_pkg
// field widths, operation and status codes, and the chain command type
// ----------------------------------------------------------------------------
`default_nettype none

package pleu_pkg;

	localparam int OP_W   = 2;
	localparam int POS_W  = 5;
	localparam int WORD_W = 32;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 5;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

	typedef logic signed [WORD_W-1:0] word_t;

	// what the chain does this cycle
	typedef struct packed {
		logic ins;
		logic rem;
	} chain_cmd_t;

endpackage

`default_nettype wire

// ----- src/pleu_if.sv -----
// ----------------------------------------------------------------------------
// pleu channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface pleu_req_if;
	logic                               valid;
	logic                               ready;
	logic [pleu_pkg::OP_W-1:0]          op;
	logic [pleu_pkg::POS_W-1:0]         position;
	logic signed [pleu_pkg::WORD_W-1:0] value;

	modport source (output valid, op, position, value, input ready);
	modport sink (input valid, op, position, value, output ready);
endinterface

interface pleu_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [pleu_pkg::WORD_W-1:0] data;
	logic [pleu_pkg::STAT_W-1:0]        status;
	logic [pleu_pkg::CNT_W-1:0]         count;

	modport source (output valid, data, status, count, input ready);
	modport sink (input valid, data, status, count, output ready);
endinterface

`default_nettype wire

// ----- src/pleu_cell.sv -----
// ----------------------------------------------------------------------------
// pleu_cell
// one list slot: holds, loads a new word, or takes a neighbor's word
// ----------------------------------------------------------------------------
`default_nettype none

module pleu_cell #(
	parameter int IDX = 0,
	parameter int FW  = 5
) (
	input  wire logic                 clk,
	input  wire pleu_pkg::chain_cmd_t cmd,
	input  wire logic [FW-1:0]        slot,
	input  wire logic [FW-1:0]        fill,
	input  wire pleu_pkg::word_t      value,
	input  wire pleu_pkg::word_t      left,
	input  wire pleu_pkg::word_t      right,
	output pleu_pkg::word_t           word,
	output pleu_pkg::word_t           rd
);
	import pleu_pkg::*;

	localparam logic [FW-1:0] IDX_F  = FW'(IDX);
	localparam logic [FW-1:0] IDX_N  = FW'(IDX + 1);

	word_t word_q;

	logic here;
	assign here = (slot == IDX_F);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (here) begin
				word_q <= value;
			end else if ((IDX_F > slot) && (IDX_F <= fill)) begin
				word_q <= left;
			end
		end else if (cmd.rem) begin
			// close the gap: slots from the removed one up to the one before the last filled slot take their right side
			if ((IDX_F >= slot) && (IDX_N < fill)) begin
				word_q <= right;
			end
		end
	end

	assign word = word_q;
	assign rd   = here ? word_q : '0;

endmodule

`default_nettype wire

// ----- src/pleu_chain.sv -----
// ----------------------------------------------------------------------------
// pleu_chain
// row of list cells with neighbor links and a selected-word read
// ----------------------------------------------------------------------------
`default_nettype none

module pleu_chain #(
	parameter int DEPTH = 16,
	parameter int FW    = 5
) (
	input  wire logic                 clk,
	input  wire pleu_pkg::chain_cmd_t cmd,
	input  wire logic [FW-1:0]        slot,
	input  wire logic [FW-1:0]        fill,
	input  wire pleu_pkg::word_t      value,
	output pleu_pkg::word_t           rd_word
);
	import pleu_pkg::*;

	word_t words [DEPTH];
	word_t rds   [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t lft;
		word_t rgt;

		if (i == 0) begin : g_first
			assign lft = '0;
		end else begin : g_mid_l
			assign lft = words[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rgt = words[i];
		end else begin : g_mid_r
			assign rgt = words[i+1];
		end

		pleu_cell #(
			.IDX (i),
			.FW  (FW)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.slot  (slot),
			.fill  (fill),
			.value (value),
			.left  (lft),
			.right (rgt),
			.word  (words[i]),
			.rd    (rds[i])
		);
	end

	// at most one cell drives a nonzero word
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_word = rd_word | rds[i];
		end
	end

endmodule

`default_nettype wire

// ----- src/positional_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// ordered list of signed words with positional insert, remove and read
// ----------------------------------------------------------------------------
//  channel  role    fields
//  req      sink    op, position, value
//  rsp      source  data, status, count
//
//  one item per cycle: each cell shifts or holds in parallel on a slot
//  compare, the result lands in the response register on the same edge
//  req.ready stays high while the response register is empty or is read
//  reset clears the fill count and the response valid; cell words are not reset
//  a stalled response holds req.ready low until the transfer completes
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_unit #(
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	pleu_req_if.sink   req,
	pleu_rsp_if.source rsp
);
	import pleu_pkg::*;

	localparam int FW = $clog2(DEPTH + 1);
	localparam int PW = (FW > POS_W) ? FW : POS_W;

	logic [FW-1:0]     fill_q;
	logic              rvalid_q;
	word_t             data_q;
	logic [STAT_W-1:0] status_q;
	logic [CNT_W-1:0]  count_q;

	logic              take;
	logic [PW-1:0]     pos_e;
	logic [PW-1:0]     fill_e;
	logic              in_range;
	logic              full;
	logic              empty;
	logic [FW-1:0]     pos_m1;
	logic [FW-1:0]     slot;
	chain_cmd_t        cmd;
	word_t             rd_word;
	logic [FW-1:0]     fill_d;
	word_t             data_d;
	logic [STAT_W-1:0] status_d;

	assign req.ready = !rvalid_q || rsp.ready;
	assign take      = req.valid && req.ready;

	assign pos_e    = PW'(req.position);
	assign fill_e   = PW'(fill_q);
	assign in_range = (pos_e != '0) && (pos_e <= fill_e);
	assign full     = (fill_q == FW'(DEPTH));
	assign empty    = (fill_q == '0);
	assign pos_m1   = FW'(pos_e - PW'(1));

	always_comb begin
		cmd      = '0;
		slot     = pos_m1;
		fill_d   = fill_q;
		data_d   = '0;
		status_d = ST_BADPOS;
		unique case (req.op)
			OP_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					slot     = in_range ? pos_m1 : fill_q;
					cmd.ins  = take;
					fill_d   = fill_q + FW'(1);
					status_d = ST_OK;
				end
			end
			OP_REMOVE: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					slot     = in_range ? pos_m1 : fill_q - FW'(1);
					cmd.rem  = take;
					fill_d   = fill_q - FW'(1);
					data_d   = rd_word;
					status_d = ST_OK;
				end
			end
			OP_READ: begin
				if (in_range) begin
					data_d   = rd_word;
					status_d = ST_OK;
				end
			end
			default: begin
				status_d = ST_BADPOS;
			end
		endcase
	end

	pleu_chain #(
		.DEPTH (DEPTH),
		.FW    (FW)
	) u_chain (
		.clk     (clk),
		.cmd     (cmd),
		.slot    (slot),
		.fill    (fill_q),
		.value   (req.value),
		.rd_word (rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (take) begin
				fill_q   <= fill_d;
				rvalid_q <= 1'b1;
			end else if (rsp.ready) begin
				rvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q   <= data_d;
			status_q <= status_d;
			count_q  <= CNT_W'(fill_d);
		end
	end

	assign rsp.valid  = rvalid_q;
	assign rsp.data   = data_q;
	assign rsp.status = status_q;
	assign rsp.count  = count_q;

endmodule

`default_nettype wire

// ----- src/pleu_checker.sv -----
// ----------------------------------------------------------------------------
// pleu_checker
// port-level checks on the list engine response channel
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_list_engine_unit_assert.svh"

module pleu_checker #(
	parameter int DEPTH = 16
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           req_valid,
	input wire logic                           req_ready,
	input wire logic                           rsp_valid,
	input wire logic                           rsp_ready,
	input wire logic signed [pleu_pkg::WORD_W-1:0] rsp_data,
	input wire logic [pleu_pkg::STAT_W-1:0]    rsp_status,
	input wire logic [pleu_pkg::CNT_W-1:0]     rsp_count
);
	import pleu_pkg::*;

	// a pending response stays until its transfer
	`PLEU_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

	// every request transfer yields a response on the next cycle
	`PLEU_ASSERT_NEXT(a_rsp_follows, clk, arst_n, req_valid && req_ready, rsp_valid, "no response after request transfer")

	`PLEU_ASSERT_NOW(a_full_count, clk, arst_n, rsp_valid && (rsp_status == ST_FULL), (rsp_count == CNT_W'(DEPTH)) && (rsp_data == '0), "full reported with wrong count or data")

	`PLEU_ASSERT_NOW(a_empty_count, clk, arst_n, rsp_valid && (rsp_status == ST_EMPTY), (rsp_count == '0) && (rsp_data == '0), "empty reported with wrong count or data")

	`PLEU_ASSERT_NOW(a_badpos_data, clk, arst_n, rsp_valid && (rsp_status == ST_BADPOS), rsp_data == '0, "bad position with nonzero data")

endmodule

bind positional_list_engine_unit pleu_checker #(
	.DEPTH (DEPTH)
) u_pleu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_data   (rsp.data),
	.rsp_status (rsp.status),
	.rsp_count  (rsp.count)
);

`default_nettype wire

// ----- tb/sv/tb_positional_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// tb_positional_list_engine_unit
// self-checking bench for the positional list engine: a shadow copy of the
// list predicts data, status and count for every request transfer, and each
// response transfer is compared in order against it; both channels idle and
// stall in random bursts except during the closing stretch of the run
// ----------------------------------------------------------------------------

module tb_positional_list_engine_unit;

	timeunit 1ns;
	timeprecision 1ps;

	import pleu_pkg::*;

	localparam int LIST_DEPTH   = 16;
	localparam int RANDOM_ITEMS = 1900;
	localparam int STEADY_ITEMS = 300;
	localparam int STALL_LIMIT  = 1000;

	// op code 3 carries no meaning
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam word_t WORD_MAX = 32'sh7fffffff;
	localparam word_t WORD_MIN = 32'sh80000000;

	typedef struct packed {
		word_t               data;
		logic [STAT_W-1:0]   status;
		logic [CNT_W-1:0]    count;
	} list_result_t;

	class list_shadow;
		word_t        cells[LIST_DEPTH];
		int           fill;
		int           peak_fill;
		int           errors;
		int           n_checked;
		int           n_status[4];
		list_result_t expected_results[$];

		function void apply_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, word_t val);
			list_result_t r;
			int           slot;
			int           k;
			r.data   = '0;
			r.status = ST_OK;
			case (op)
				OP_INSERT: begin
					if (fill >= LIST_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						slot = (pos == 0 || pos > fill) ? fill : pos - 1;
						for (k = fill; k > slot; k--)
							cells[k] = cells[k - 1];
						cells[slot] = val;
						fill++;
					end
				end
				OP_REMOVE: begin
					if (fill == 0) begin
						r.status = ST_EMPTY;
					end else begin
						slot = (pos == 0 || pos > fill) ? fill - 1 : pos - 1;
						r.data = cells[slot];
						for (k = slot; k + 1 < fill; k++)
							cells[k] = cells[k + 1];
						fill--;
					end
				end
				OP_READ: begin
					if (pos == 0 || pos > fill)
						r.status = ST_BADPOS;
					else
						r.data = cells[pos - 1];
				end
				default: begin
					r.status = ST_BADPOS;
				end
			endcase
			r.count = fill[CNT_W-1:0];
			if (fill > peak_fill)
				peak_fill = fill;
			expected_results.push_back(r);
		endfunction

		function void check_result(word_t data, logic [STAT_W-1:0] status,
				logic [CNT_W-1:0] count);
			list_result_t e;
			if (expected_results.size() == 0) begin
				$error("response transfer with no result pending: data %0d status %0d count %0d",
					data, status, count);
				errors++;
				return;
			end
			e = expected_results.pop_front();
			n_checked++;
			n_status[e.status]++;
			if (data !== e.data) begin
				$error("data: expected %0d, got %0d", e.data, data);
				errors++;
			end
			if (status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, status);
				errors++;
			end
			if (count !== e.count) begin
				$error("count: expected %0d, got %0d", e.count, count);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	pleu_req_if req ();
	pleu_rsp_if rsp ();

	positional_list_engine_unit #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	list_shadow shadow = new();

	bit steady;      // closing stretch: no idling on either side
	bit send_gaps;   // sender idles in bursts during this stretch
	int n_sent;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// drive one request and wait for its transfer
	task automatic push_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input word_t val);
		if (!steady && send_gaps && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req.valid    <= 1'b1;
		req.op       <= op;
		req.position <= pos;
		req.value    <= val;
		do
			@(posedge clk);
		while (!req.ready);
		shadow.apply_request(op, pos, val);
		n_sent++;
	endtask

	// response side: random stall bursts, check every transfer
	initial begin
		int  stall_left;
		int  phase_left;
		bit  stalls_on;
		rsp.ready = 1'b0;
		stall_left = 0;
		phase_left = 0;
		stalls_on = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready)
				shadow.check_result(rsp.data, rsp.status, rsp.count);
			if (phase_left == 0) begin
				phase_left = $urandom_range(50, 200);
				stalls_on = ($urandom_range(0, 2) != 0);
			end
			phase_left--;
			if (steady) begin
				stall_left = 0;
				rsp.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 13) - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("tb_positional_list_engine_unit NOT OK");
				$finish;
			end
		end
	end

	initial begin
		int                ins_pos[16];
		int                ins_cut;
		int                rem_cut;
		int                r;
		int                p;
		logic [OP_W-1:0]   op;
		word_t             val;

		ins_pos      = '{0, 1, 31, 2, 16, 3, 1, 0, 17, 5, 8, 2, 10, 30, 1, 4};
		arst_n       = 1'b0;
		req.valid    = 1'b0;
		req.op       = OP_READ;
		req.position = '0;
		req.value    = '0;
		steady       = 1'b0;
		send_gaps    = 1'b0;
		n_sent       = 0;
		ins_cut      = 40;
		rem_cut      = 70;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, meaningless op
		push_request(OP_READ, 5'd1, '0);
		push_request(OP_REMOVE, 5'd3, '0);
		push_request(OP_UNUSED, 5'd5, 32'sh1234);
		// fill to the top with extreme and random words at scattered positions
		for (int i = 0; i < 16; i++) begin
			case (i % 5)
				0: val = WORD_MAX;
				1: val = WORD_MIN;
				2: val = -1;
				3: val = '0;
				default: val = $urandom;
			endcase
			push_request(OP_INSERT, ins_pos[i][POS_W-1:0], val);
		end
		push_request(OP_INSERT, 5'd9, 32'sd5);
		push_request(OP_READ, 5'd16, '0);
		push_request(OP_READ, 5'd17, '0);
		push_request(OP_READ, 5'd0, '0);
		push_request(OP_REMOVE, 5'd1, '0);
		push_request(OP_REMOVE, 5'd0, '0);
		push_request(OP_REMOVE, 5'd20, '0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				send_gaps = ($urandom_range(0, 2) != 0);
				case ($urandom_range(0, 3))
					0: begin ins_cut = 60; rem_cut = 75; end   // grow toward full
					1: begin ins_cut = 20; rem_cut = 75; end   // drain toward empty
					2: begin ins_cut = 40; rem_cut = 70; end
					default: begin ins_cut = 25; rem_cut = 45; end
				endcase
			end
			if (n == RANDOM_ITEMS - STEADY_ITEMS)
				steady = 1'b1;
			r = $urandom_range(0, 99);
			if (r >= 98)
				op = OP_UNUSED;
			else if (r < ins_cut)
				op = OP_INSERT;
			else if (r < rem_cut)
				op = OP_REMOVE;
			else
				op = OP_READ;
			// mostly positions around the current fill, some anywhere in the field
			if ($urandom_range(0, 9) < 7)
				p = $urandom_range(0, shadow.fill + 1);
			else
				p = $urandom_range(0, 31);
			case ($urandom_range(0, 9))
				0: val = WORD_MAX;
				1: val = WORD_MIN;
				2: val = $signed($urandom_range(0, 15)) - 8;
				default: val = $urandom;
			endcase
			push_request(op, p[POS_W-1:0], val);
		end
		req.valid <= 1'b0;

		while (shadow.expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d requests, %0d results checked: %0d ok, %0d full, %0d empty, %0d bad position",
			n_sent, shadow.n_checked, shadow.n_status[ST_OK], shadow.n_status[ST_FULL],
			shadow.n_status[ST_EMPTY], shadow.n_status[ST_BADPOS]);
		$display("list reached %0d of %0d entries, %0d mismatches", shadow.peak_fill,
			LIST_DEPTH, shadow.errors);
		if (shadow.errors == 0)
			$display("tb_positional_list_engine_unit OK");
		else
			$display("tb_positional_list_engine_unit NOT OK");
		$finish;
	end

endmodule
